### rtl/core/ilid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed list block.
// Used by ilid_cell and indexed_list_insert_delete_top; no dependencies.
package ilid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int FIELD_POS_W  = 7;
    localparam int LEN_W        = 7;
    // wide enough for an index or count at the largest supported capacity (4096)
    localparam int POS_W        = 13;

    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 40;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    // broadcast to every cell in the row
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

### rtl/core/ilid_cell.sv
`timescale 1ns / 1ps
// One list slot: holds one entry and shifts with its neighbors on insert/delete.
// Depends on ilid_pkg.
module ilid_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  ilid_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [ilid_pkg::DATA_W-1:0] i_left,
    input  logic signed [ilid_pkg::DATA_W-1:0] i_right,
    output logic signed [ilid_pkg::DATA_W-1:0] o_value,
    output logic signed [ilid_pkg::DATA_W-1:0] o_rd
);

    localparam logic [ilid_pkg::POS_W-1:0] CellIdx = ilid_pkg::POS_W'(IDX);

    logic signed [ilid_pkg::DATA_W-1:0] r_val;
    logic signed [ilid_pkg::DATA_W-1:0] n_val;
    logic                               at_pos;
    logic                               above_pos;

    assign at_pos    = (CellIdx == i_ctrl.pos);
    assign above_pos = (CellIdx > i_ctrl.pos);

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            if (above_pos) begin
                n_val = i_left;
            end else if (at_pos) begin
                n_val = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (above_pos || at_pos) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    // read contribution, zero unless this slot is addressed
    assign o_rd    = at_pos ? r_val : '0;

endmodule

### rtl/core/indexed_list_insert_delete_top.sv
`timescale 1ns / 1ps
// Bounded ordered list of signed 32-bit values: get, add at head, add at tail,
// insert before a position and delete at a position, one result beat per
// operation carrying the value read (-1 unless an accepted get), an accepted
// flag and the new length. Entries live in a row of CAPACITY cells that all
// shift in the same cycle, so a beat is taken each cycle the result register
// is empty or being drained, and its registered result appears in the next
// cycle. Depends on ilid_pkg and ilid_cell.
module indexed_list_insert_delete_top #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] op, [9:3] position, [41:10] item_value, [47:42] zero
    input  logic [ilid_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] read_value, [32] accepted, [39:33] list_length
    output logic [ilid_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = ilid_pkg::DATA_W;

    logic [ilid_pkg::OP_W-1:0]        op;
    logic [ilid_pkg::FIELD_POS_W-1:0] position;
    logic signed [DW-1:0]             item_value;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic signed [DW-1:0]      r_read_value;
    logic                      r_accepted;
    logic [ilid_pkg::LEN_W-1:0] r_length;

    logic                      in_fire;
    logic                      full;
    logic                      ok;
    logic                      is_ins;
    logic                      is_del;
    logic                      is_get;
    logic [ilid_pkg::POS_W-1:0] pos_ext;
    logic [ilid_pkg::POS_W-1:0] cnt_ext;
    logic [ilid_pkg::POS_W-1:0] ins_pos;
    ilid_pkg::t_cell_ctrl      ctrl;

    logic signed [DW-1:0] cell_val [CAPACITY];
    logic signed [DW-1:0] cell_rd  [CAPACITY];
    logic signed [DW-1:0] rd_or;

    assign op         = s_axis_tdata[2:0];
    assign position   = s_axis_tdata[9:3];
    assign item_value = s_axis_tdata[41:10];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign pos_ext = ilid_pkg::POS_W'(position);
    assign cnt_ext = ilid_pkg::POS_W'(r_count);
    assign full    = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        ok      = 1'b0;
        is_ins  = 1'b0;
        is_del  = 1'b0;
        is_get  = 1'b0;
        ins_pos = pos_ext;
        unique case (op)
            ilid_pkg::OP_GET: begin
                is_get = 1'b1;
                ok     = (pos_ext < cnt_ext);
            end
            ilid_pkg::OP_HEAD: begin
                is_ins  = 1'b1;
                ins_pos = '0;
                ok      = !full;
            end
            ilid_pkg::OP_TAIL: begin
                is_ins  = 1'b1;
                ins_pos = cnt_ext;
                ok      = !full;
            end
            ilid_pkg::OP_INSERT: begin
                is_ins = 1'b1;
                ok     = !full && (pos_ext <= cnt_ext);
            end
            ilid_pkg::OP_DELETE: begin
                is_del = 1'b1;
                ok     = (pos_ext < cnt_ext);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        ctrl.ins   = in_fire && is_ins && ok;
        ctrl.del   = in_fire && is_del && ok;
        ctrl.pos   = ins_pos;
        ctrl.value = item_value;
    end

    always_comb begin
        n_count = r_count;
        if (ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DW-1:0] left;
        logic signed [DW-1:0] right;
        if (g == 0) begin : g_first
            assign left = item_value;
        end else begin : g_mid_l
            assign left = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_val[g];
        end else begin : g_mid_r
            assign right = cell_val[g+1];
        end
        ilid_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (ctrl),
            .i_left (left),
            .i_right(right),
            .o_value(cell_val[g]),
            .o_rd   (cell_rd[g])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_read_value <= (is_get && ok) ? rd_or : '1;
            r_accepted   <= ok;
            r_length     <= ilid_pkg::LEN_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_length, r_accepted, r_read_value};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_refuse_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !ok |=> $stable(r_count))
        else $error("refused operation changed the length");

    a_refused_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_accepted |-> r_read_value == '1)
        else $error("refused beat carries a read value");

endmodule
